// ===== src/swps_pkg.sv =====
// ----------------------------------------------------------------------------
// Sliding window popcount sum package
// Shared widths, defaults and the 32-bit population count function.
// ----------------------------------------------------------------------------
package swps_pkg;

   localparam int DEFAULT_WINDOW = 1024;
   localparam int DATA_W         = 32;
   localparam int COUNT_W        = 6;
   localparam int ONES_W         = 16;
   localparam int INDEX_W        = 32;
   localparam int BITS_PER_WORD  = 32;

   localparam logic [ONES_W-1:0] ONES_MAX = '1;

   // Parallel bit count: pairs, nibbles, bytes, then the bytes are folded
   // into the lowest byte.
   function automatic logic [COUNT_W-1:0] ones_in_word(input logic [DATA_W-1:0] w);
      logic [DATA_W-1:0] pairs;
      logic [DATA_W-1:0] nibbles;
      logic [DATA_W-1:0] bytes;
      logic [DATA_W-1:0] halves;
      logic [DATA_W-1:0] total;
      pairs   = w - ((w >> 1) & 32'h5555_5555);
      nibbles = (pairs & 32'h3333_3333) + ((pairs >> 2) & 32'h3333_3333);
      bytes   = (nibbles + (nibbles >> 4)) & 32'h0F0F_0F0F;
      halves  = bytes + (bytes >> 8);
      total   = halves + (halves >> 16);
      return total[COUNT_W-1:0];
   endfunction

endpackage

// ===== src/swps_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module swps_ram #(
   parameter int WIDTH = swps_pkg::COUNT_W,
   parameter int DEPTH = swps_pkg::DEFAULT_WINDOW,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/sliding_window_popcount_sum.sv =====
// ----------------------------------------------------------------------------
// Sliding window popcount sum
// Counts the one bits of each 32-bit word and reports their sum over the
// last WINDOW words.
// ----------------------------------------------------------------------------
// One request is taken in every cycle unless rsp_stall holds the result
// register, and its result appears on the outputs from a register: the word
// is registered, its bit count and the running sum update are formed in one
// pass, and the sum lands in the result register. The rate is set by the ring
// memory (WINDOW entries of 6 bits, one write and one read per cycle) and the
// single add/subtract of the running sum. The first WINDOW-1 requests give no
// result; from the WINDOW-th on, every request gives the window sum with an
// index counting from zero and wrapping at 32 bits. The sum saturates at
// 65535 when WINDOW*32 exceeds that. The ring needs no clearing after reset,
// so the block is ready at once.
module sliding_window_popcount_sum #(
   parameter int WINDOW = swps_pkg::DEFAULT_WINDOW
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [swps_pkg::DATA_W-1:0]    req_data_word,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [swps_pkg::ONES_W-1:0]    rsp_window_ones,
   output logic [swps_pkg::INDEX_W-1:0]   rsp_window_index
);

   localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int SUM_W  = $clog2(WINDOW * swps_pkg::BITS_PER_WORD + 1);
   localparam int CMP_W  = (SUM_W > swps_pkg::ONES_W) ? SUM_W : swps_pkg::ONES_W;

   // Input register
   logic                          word_valid_ff;
   logic [swps_pkg::DATA_W-1:0]   word_ff;

   // Window state
   logic [POS_W-1:0]              wpos_ff, wpos_in;
   logic [FILL_W-1:0]             fill_ff, fill_in;
   logic [SUM_W-1:0]              sum_ff, sum_in;
   logic [swps_pkg::INDEX_W-1:0]  index_ff, index_in;

   // Result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [swps_pkg::ONES_W-1:0]   rsp_ones_ff, rsp_ones_in;
   logic [swps_pkg::INDEX_W-1:0]  rsp_index_ff;

   logic                          out_free;
   logic                          advance;
   logic                          full;
   logic                          emit;
   logic [swps_pkg::COUNT_W-1:0]  ones;
   logic [swps_pkg::COUNT_W-1:0]  oldest;
   logic [POS_W-1:0]              wpos_next;
   logic [POS_W-1:0]              rd_addr;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = word_valid_ff && out_free;
   assign req_stall = word_valid_ff && !out_free;

   assign full      = (fill_ff == FILL_W'(WINDOW));
   assign ones      = swps_pkg::ones_in_word(word_ff);
   assign wpos_next = (wpos_ff == POS_W'(WINDOW - 1)) ? '0 : wpos_ff + POS_W'(1);

   // The read port always looks at the slot of the word that will sit in
   // the input register next cycle, so the oldest count is ready in time.
   // That slot differs from the one being written only if the window holds
   // at least two words, which the block itself does not enforce.
   assign rd_addr = advance ? wpos_next : wpos_ff;

   swps_ram #(
      .WIDTH (swps_pkg::COUNT_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (advance),
      .wr_addr (wpos_ff),
      .wr_data (ones),
      .rd_addr (rd_addr),
      .rd_data (oldest)
   );

   always_comb begin
      wpos_in      = wpos_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      index_in     = index_ff;
      emit         = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ones_in  = rsp_ones_ff;
      if (advance) begin
         wpos_in = wpos_next;
         if (full) begin
            sum_in = sum_ff - SUM_W'(oldest) + SUM_W'(ones);
            emit   = 1'b1;
         end else begin
            sum_in  = sum_ff + SUM_W'(ones);
            fill_in = fill_ff + FILL_W'(1);
            emit    = (fill_in == FILL_W'(WINDOW));
         end
         rsp_valid_in = emit;
         if (emit) begin
            index_in = index_ff + swps_pkg::INDEX_W'(1);
         end
         if (CMP_W'(sum_in) > CMP_W'(swps_pkg::ONES_MAX)) begin
            rsp_ones_in = swps_pkg::ONES_MAX;
         end else begin
            rsp_ones_in = swps_pkg::ONES_W'(sum_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= 1'b0;
         wpos_ff       <= '0;
         fill_ff       <= '0;
         sum_ff        <= '0;
         index_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (!req_stall) begin
            word_valid_ff <= req_valid;
         end
         wpos_ff      <= wpos_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         index_ff     <= index_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         word_ff <= req_data_word;
      end
      rsp_ones_ff <= rsp_ones_in;
      if (advance) begin
         rsp_index_ff <= index_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_window_ones  = rsp_ones_ff;
   assign rsp_window_index = rsp_index_ff;

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WINDOW))
      else $error("fill level beyond window size");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      wpos_ff <= POS_W'(WINDOW - 1))
      else $error("ring position beyond window size");

   a_result_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> full)
      else $error("result shown before the window filled");

   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      (advance && emit) |=> (index_ff == $past(index_ff) + swps_pkg::INDEX_W'(1)))
      else $error("result index did not advance by one");
`endif

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Sliding window popcount sum testbench
// Feeds 32-bit words into the block and checks each window sum and its index
// against a bit-accurate predictor of the ring and the running sum. The
// stimulus runs from the field extremes and the ring filling, through a long
// result hold-off and a full drain, to biased random runs that sweep the sum.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int WIN = swps_pkg::DEFAULT_WINDOW;

   typedef struct packed {
      logic [swps_pkg::ONES_W-1:0]  ones;
      logic [swps_pkg::INDEX_W-1:0] index;
   } window_sum_type;

   typedef enum int {MIXED_WORDS, DENSE_WORDS, SPARSE_WORDS} word_mix_type;

   localparam logic [31:0] EDGE_WORDS [16] = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
      32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_0000,
      32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
      32'h0101_0101, 32'hFEFE_FEFE, 32'h0001_0000, 32'hFFFE_FFFF
   };

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [swps_pkg::DATA_W-1:0]    req_data_word = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [swps_pkg::ONES_W-1:0]    rsp_window_ones;
   logic [swps_pkg::INDEX_W-1:0]   rsp_window_index;

   // Predictor state: the ring of bit counts and the running sum.
   logic [5:0]  ring_counts [WIN];
   int unsigned ring_total = 0;
   int unsigned ring_filled = 0;
   int unsigned ring_slot = 0;
   logic [31:0] next_index = '0;

   window_sum_type pending_sums [$];
   int          errors = 0;
   bit          sender_idles = 1'b0;
   bit          receiver_idles = 1'b0;
   int          hold_left = 0;

   sliding_window_popcount_sum #(.WINDOW(WIN)) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_word    (req_data_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_window_ones  (rsp_window_ones),
      .rsp_window_index (rsp_window_index)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic void predict_window(input logic [31:0] w);
      int unsigned ones;
      window_sum_type due;
      ones = $countones(w);
      if (ring_filled < WIN) begin
         ring_total  += ones;
         ring_filled += 1;
      end else begin
         ring_total = ring_total - ring_counts[ring_slot] + ones;
      end
      ring_counts[ring_slot] = ones[5:0];
      ring_slot = (ring_slot + 1) % WIN;
      if (ring_filled == WIN) begin
         due.ones  = (ring_total > swps_pkg::ONES_MAX) ? swps_pkg::ONES_MAX
                                                       : ring_total[15:0];
         due.index = next_index;
         next_index = next_index + 1;
         pending_sums.push_back(due);
      end
   endfunction

   function automatic void check_window_sum(input logic [15:0] ones,
                                            input logic [31:0] index);
      window_sum_type due;
      if (pending_sums.size() == 0) begin
         $error("unexpected result: window_ones %0d window_index %0d", ones, index);
         errors++;
         return;
      end
      due = pending_sums.pop_front();
      if (ones !== due.ones) begin
         $error("window_ones: expected %0d, actual %0d", due.ones, ones);
         errors++;
      end
      if (index !== due.index) begin
         $error("window_index: expected %0d, actual %0d", due.index, index);
         errors++;
      end
   endfunction

   // Both handshakes are sampled before the edge updates anything.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) predict_window(req_data_word);
         if (rsp_valid && !rsp_stall) check_window_sum(rsp_window_ones, rsp_window_index);
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   initial begin
      int   idle_left;
      logic stall_next;
      idle_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            stall_next = 1'b1;
            hold_left--;
         end else if (idle_left > 0) begin
            stall_next = 1'b1;
            idle_left--;
         end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
            stall_next = 1'b1;
            idle_left  = idle_length() - 1;
         end else begin
            stall_next = 1'b0;
         end
         rsp_stall <= stall_next;
      end
   end

   function automatic logic [31:0] random_word(input word_mix_type mix);
      int          pick;
      logic [31:0] one_bit;
      pick    = $urandom_range(0, 9);
      one_bit = 32'h1 << $urandom_range(0, 31);
      case (mix)
         DENSE_WORDS: begin
            if (pick < 4) return '1;
            if (pick < 6) return ~one_bit;
            return $urandom | $urandom | $urandom;
         end
         SPARSE_WORDS: begin
            if (pick < 4) return '0;
            if (pick < 6) return one_bit;
            return $urandom & $urandom & $urandom;
         end
         default: begin
            case (pick)
               0: return '1;
               1: return '0;
               2: return one_bit;
               3: return ~one_bit;
               4: return $urandom | $urandom;
               5: return $urandom & $urandom;
               default: return $urandom;
            endcase
         end
      endcase
   endfunction

   // Called at a falling edge; returns at a falling edge with the request
   // still offered unless a gap was taken.
   task automatic send_word(input logic [31:0] w);
      int gap;
      req_valid     <= 1'b1;
      req_data_word <= w;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
      gap = 0;
      if (sender_idles && $urandom_range(0, 99) < 45) gap = idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Withdraws the request and waits for the next falling edge.
   task automatic sender_rest();
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      while (pending_sums.size() != 0) @(negedge clock);
   endtask

   task automatic test_extremes();
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      foreach (EDGE_WORDS[i]) send_word(EDGE_WORDS[i]);
      sender_rest();
   endtask

   // Stops one request short of a full ring, so no result may appear yet.
   task automatic test_fill();
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      repeat (WIN - 1 - $size(EDGE_WORDS)) send_word(random_word(MIXED_WORDS));
      sender_rest();
   endtask

   // The first full window and the two after it, back to back.
   task automatic test_window_edge();
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      send_word('1);
      send_word('0);
      send_word('1);
      sender_rest();
   endtask

   // The result side holds off long enough for the block to stall requests.
   task automatic test_backpressure();
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      hold_left      = 300;
      repeat (80) send_word(random_word(DENSE_WORDS));
      sender_rest();
   endtask

   task automatic test_drain_pause();
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      repeat (40) send_word(random_word(MIXED_WORDS));
      sender_rest();
      wait_for_drain();
      repeat (40) send_word(random_word(SPARSE_WORDS));
      sender_rest();
   endtask

   // Runs of dense, sparse and mixed words drive the window sum up and down.
   task automatic test_random_runs();
      word_mix_type mix;
      for (int run = 0; run < 6; run++) begin
         sender_idles   = (run % 3) != 2;
         receiver_idles = (run % 2) != 0;
         mix = (run % 3 == 0) ? DENSE_WORDS : ((run % 3 == 1) ? SPARSE_WORDS : MIXED_WORDS);
         repeat (50) send_word(random_word(mix));
      end
      sender_rest();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_extremes();
      test_fill();
      test_window_edge();
      test_backpressure();
      test_drain_pause();
      test_random_runs();
      wait_for_drain();
      repeat (10) @(negedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
